[design/ndsrgb_pkg.sv]
package ndsrgb_pkg;

  localparam int SRC_WIDTH  = 320;
  localparam int SRC_HEIGHT = 240;
  localparam int DST_WIDTH  = 96;
  localparam int DST_HEIGHT = 96;

  localparam int COL_STEP_Q = SRC_WIDTH / DST_WIDTH;
  localparam int COL_STEP_R = SRC_WIDTH % DST_WIDTH;
  localparam int ROW_STEP_Q = SRC_HEIGHT / DST_HEIGHT;
  localparam int ROW_STEP_R = SRC_HEIGHT % DST_HEIGHT;

  // source position and sample position reach SRC at most
  localparam int SCW = $clog2(SRC_WIDTH + 1);
  localparam int SRW = $clog2(SRC_HEIGHT + 1);
  // output counters reach DST, remainders stay below DST
  localparam int OCW = $clog2(DST_WIDTH + 1);
  localparam int ORW = $clog2(DST_HEIGHT + 1);

  localparam int PIX_W  = 16;
  localparam int CHAN_W = 8;
  localparam int OUT_W  = 3 * CHAN_W;

  typedef struct packed {
    logic hit;
    logic last;
  } trk_status_t;

  function automatic logic [OUT_W-1:0] expand_pixel(input logic [PIX_W-1:0] raw);
    logic [PIX_W-1:0] px;
    logic [4:0]       r5;
    logic [5:0]       g6;
    logic [4:0]       b5;
    px = {raw[7:0], raw[15:8]};
    r5 = px[15:11];
    g6 = px[10:5];
    b5 = px[4:0];
    // blue in the top byte, red in the low byte
    return {{b5, b5[4:2]}, {g6, g6[5:4]}, {r5, r5[4:2]}};
  endfunction

endpackage

[design/ndsrgb_tracker.sv]
module ndsrgb_tracker
  import ndsrgb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic        frame_start_i,
  output trk_status_t status_o
);

  logic [SCW-1:0] src_col_q, src_col_d, src_col_e;
  logic [SRW-1:0] src_row_q, src_row_d, src_row_e;
  logic [OCW-1:0] out_col_q, out_col_d, out_col_e;
  logic [ORW-1:0] out_row_q, out_row_d, out_row_e;
  logic [SCW-1:0] nxt_col_q, nxt_col_d, nxt_col_e;
  logic [SRW-1:0] nxt_row_q, nxt_row_d, nxt_row_e;
  logic [OCW-1:0] rem_col_q, rem_col_d, rem_col_e;
  logic [ORW-1:0] rem_row_q, rem_row_d, rem_row_e;

  logic           row_hit, col_hit;
  logic [OCW:0]   col_rem_sum;
  logic [ORW:0]   row_rem_sum;

  always_comb begin
    src_col_e = frame_start_i ? '0 : src_col_q;
    src_row_e = frame_start_i ? '0 : src_row_q;
    out_col_e = frame_start_i ? '0 : out_col_q;
    out_row_e = frame_start_i ? '0 : out_row_q;
    nxt_col_e = frame_start_i ? '0 : nxt_col_q;
    nxt_row_e = frame_start_i ? '0 : nxt_row_q;
    rem_col_e = frame_start_i ? '0 : rem_col_q;
    rem_row_e = frame_start_i ? '0 : rem_row_q;

    row_hit = (out_row_e < ORW'(DST_HEIGHT)) && (nxt_row_e <= src_row_e);
    col_hit = (out_col_e < OCW'(DST_WIDTH)) && (nxt_col_e <= src_col_e);

    status_o.hit  = row_hit && col_hit;
    status_o.last = (out_row_e == ORW'(DST_HEIGHT - 1)) &&
                    (out_col_e == OCW'(DST_WIDTH - 1));
  end

  always_comb begin
    src_col_d   = src_col_e;
    src_row_d   = src_row_e;
    out_col_d   = out_col_e;
    out_row_d   = out_row_e;
    nxt_col_d   = nxt_col_e;
    nxt_row_d   = nxt_row_e;
    rem_col_d   = rem_col_e;
    rem_row_d   = rem_row_e;
    col_rem_sum = {1'b0, rem_col_e} + (OCW+1)'(COL_STEP_R);
    row_rem_sum = {1'b0, rem_row_e} + (ORW+1)'(ROW_STEP_R);

    if (col_hit) begin
      out_col_d = out_col_e + OCW'(1);
      if (col_rem_sum >= (OCW+1)'(DST_WIDTH)) begin
        rem_col_d = OCW'(col_rem_sum - (OCW+1)'(DST_WIDTH));
        nxt_col_d = nxt_col_e + SCW'(COL_STEP_Q + 1);
      end else begin
        rem_col_d = OCW'(col_rem_sum);
        nxt_col_d = nxt_col_e + SCW'(COL_STEP_Q);
      end
    end

    if (src_col_e >= SCW'(SRC_WIDTH - 1)) begin
      src_col_d = '0;
      out_col_d = '0;
      nxt_col_d = '0;
      rem_col_d = '0;
      if (row_hit) begin
        out_row_d = out_row_e + ORW'(1);
        if (row_rem_sum >= (ORW+1)'(DST_HEIGHT)) begin
          rem_row_d = ORW'(row_rem_sum - (ORW+1)'(DST_HEIGHT));
          nxt_row_d = nxt_row_e + SRW'(ROW_STEP_Q + 1);
        end else begin
          rem_row_d = ORW'(row_rem_sum);
          nxt_row_d = nxt_row_e + SRW'(ROW_STEP_Q);
        end
      end
      if (src_row_e >= SRW'(SRC_HEIGHT - 1)) begin
        src_row_d = '0;
        out_row_d = '0;
        nxt_row_d = '0;
        rem_row_d = '0;
      end else begin
        src_row_d = src_row_e + SRW'(1);
      end
    end else begin
      src_col_d = src_col_e + SCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q <= '0;
      src_row_q <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      nxt_col_q <= '0;
      nxt_row_q <= '0;
      rem_col_q <= '0;
      rem_row_q <= '0;
    end else if (step_i) begin
      src_col_q <= src_col_d;
      src_row_q <= src_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      nxt_col_q <= nxt_col_d;
      nxt_row_q <= nxt_row_d;
      rem_col_q <= rem_col_d;
      rem_row_q <= rem_row_d;
    end
  end

endmodule

[design/nearest_downscale_rgb565_to_rgb888.sv]
// Nearest-neighbor downscaler, byte-swapped RGB565 in, RGB888 out.
// Slave channel: one source pixel per transaction in raster order;
//   tdata = byte-swapped RGB565 word, tuser = start of frame (resyncs the
//   column/row counters so this pixel is column 0, row 0).
// Master channel: one transaction per kept pixel; tdata = R, G, B bytes,
//   tlast marks the last pixel of the downscaled frame.
// Pixels that fall between sample positions produce no transaction.
// Path: a kept pixel sits in the input register after its slave
//   transaction and moves to the result register, which drives m_tvalid,
//   when the input register advances.
// Throughput: 1 pixel per cycle while the receiver does not stall; the
//   position update of the counter unit is combinational, so every such
//   cycle can take a new pixel.
// Reset clears all counters and both valid flags; the next pixel is taken
//   as column 0, row 0.
// When the receiver stalls, the result register holds its transaction and
//   the input register still drains pixels that yield no output; a pixel
//   that does yield one waits, and s_tready drops once both are full.
module nearest_downscale_rgb565_to_rgb888
  import ndsrgb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  input  logic [PIX_W-1:0] s_tdata_i,   // [15:0] pixel_raw
  input  logic             s_tuser_i,   // [0] frame_start
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  output logic [OUT_W-1:0] m_tdata_o,   // [7:0] red, [15:8] green, [23:16] blue
  output logic             m_tlast_o    // frame_last
);

  logic             in_valid_q;
  logic [PIX_W-1:0] in_pix_q;
  logic             in_start_q;
  logic             out_valid_q, out_valid_d;
  logic [OUT_W-1:0] out_data_q;
  logic             out_last_q;
  logic             advance;
  logic             s_take;
  trk_status_t      trk;

  always_comb begin
    advance    = in_valid_q && (!out_valid_q || m_tready_i || !trk.hit);
    s_take     = s_tvalid_i && s_tready_o;
    s_tready_o = !in_valid_q || advance;
  end

  ndsrgb_tracker u_tracker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .frame_start_i (in_start_q),
    .status_o      (trk)
  );

  always_comb begin
    out_valid_d = out_valid_q && !m_tready_i;
    if (advance && trk.hit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_tready_o) begin
        in_valid_q <= s_tvalid_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_take) begin
      in_pix_q   <= s_tdata_i;
      in_start_q <= s_tuser_i;
    end
    if (advance && trk.hit) begin
      out_data_q <= expand_pixel(in_pix_q);
      out_last_q <= trk.last;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tlast_o  = out_last_q;

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_tready_o)
    else $error("slave side blocked with empty result register");

  a_hit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && trk.hit |=> out_valid_q)
    else $error("kept pixel did not reach result register");

  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_pix_q) && $stable(in_start_q))
    else $error("stalled input register changed");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_tready_i |=> out_valid_q && $stable(out_data_q))
    else $error("pending result overwritten");

endmodule
